### hw/rtl/limit_order_book_matcher_unit_defines.svh
// Assertion macros for the order book matcher.
// Used by limit_order_book_matcher_unit; expects a clock named clk and reset rst.
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define LOBM_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("lobm assertion failed");
`define LOBM_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("lobm assertion failed");
`else
`define LOBM_ASSERT_IMPL(lbl, a, b)
`define LOBM_ASSERT_NEXT(lbl, a, b)
`endif
`endif

### hw/rtl/lobm_pkg.sv
// Shared types, constants and the heap ordering function of the order book matcher.
// No dependencies.
`timescale 1ns / 1ps
package lobm_pkg;
  localparam int BOOK_DEPTH_DEF = 1024;
  localparam int PRICE_W = 32;
  localparam int AMT_W = 32;
  localparam int KEY_W = PRICE_W + AMT_W;
  localparam int RES_W = 30;
  localparam logic [RES_W:0] BACKLOG_MOD = 31'd1000000007;
  // 2^30 mod 1000000007, used to fold the upper bits back in
  localparam int FOLD_W = 27;
  localparam logic [FOLD_W-1:0] FOLD_K = 27'd73741817;
  localparam logic BOOK_BUY = 1'b0;
  localparam logic BOOK_SELL = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MATCH_RD, ST_MATCH_CHK, ST_POP_RD, ST_SD_L, ST_SD_R, ST_SD_DEC,
    ST_INS, ST_SU_P, ST_SU_DEC, ST_MOD_GO, ST_MOD_WAIT
  } lobm_state_t;

  function automatic logic ahead(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b,
                                 input logic is_max);
    ahead = is_max ? (a > b) : (a < b);
  endfunction
endpackage

### hw/rtl/lobm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module lobm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/lobm_modred.sv
// Reduction of the backlog total modulo 1000000007 by folding the bits above 2^30
// back in, one fold per cycle, then one compare and subtract. Depends on lobm_pkg.
`timescale 1ns / 1ps
module lobm_modred #(
  parameter int IN_W = 44
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [IN_W-1:0]           value,
  output logic                      done,
  output logic [lobm_pkg::RES_W-1:0] result
);
  import lobm_pkg::*;

  localparam int HI_W = IN_W - RES_W;
  localparam int PROD_W = HI_W + FOLD_W;

  logic [IN_W-1:0]   acc;
  logic              run;
  logic [HI_W-1:0]   hi;
  logic [RES_W-1:0]  lo;
  logic [PROD_W-1:0] prod;
  logic [IN_W-1:0]   folded;
  logic [RES_W:0]    lo_ext;
  logic [RES_W:0]    lo_sub;

  assign hi     = acc[IN_W-1:RES_W];
  assign lo     = acc[RES_W-1:0];
  assign prod   = PROD_W'(hi) * PROD_W'(FOLD_K);
  assign folded = IN_W'(lo) + IN_W'(prod);
  assign lo_ext = {1'b0, lo};
  assign lo_sub = lo_ext - BACKLOG_MOD;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && hi == '0) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= value;
    end else if (run) begin
      if (hi != '0) begin
        acc <= folded;
      end else begin
        result <= (lo_ext >= BACKLOG_MOD) ? lo_sub[RES_W-1:0] : lo;
      end
    end
  end
endmodule

### hw/rtl/limit_order_book_matcher_unit.sv
// Limit order book matcher: takes one order per start, gives one result on done.
// Each order is matched against the opposite book one entry at a time, with a heap
// sift-down for each book entry matched; any rest is then put in its own book with a
// sift-up unless that book is full, and last the backlog is reduced modulo 1000000007.
// The heap sequencer shares one read and one write port per book, and the backlog
// modulo folds the upper bits back in one pass per cycle. busy stays high until done,
// which is a one-cycle strobe that the receiver must take as it comes.
// Depends on lobm_pkg, lobm_ram, lobm_modred and the defines header.
`timescale 1ns / 1ps
`include "limit_order_book_matcher_unit_defines.svh"
module limit_order_book_matcher_unit #(
  parameter int BOOK_DEPTH = lobm_pkg::BOOK_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [lobm_pkg::PRICE_W-1:0] price,
  input  logic [lobm_pkg::AMT_W-1:0]   amount,
  input  logic                       side,
  output logic                       done,
  output logic [lobm_pkg::AMT_W-1:0]   filled_amount,
  output logic [lobm_pkg::RES_W-1:0]   backlog_mod,
  output logic                       book_full
);
  import lobm_pkg::*;

  localparam int AW = $clog2(BOOK_DEPTH);
  localparam int CW = $clog2(BOOK_DEPTH + 1);
  localparam int BW = AMT_W + CW + 1;

  lobm_state_t state, state_next;

  logic [PRICE_W-1:0] px;
  logic [AMT_W-1:0]   amt, amt_next;
  logic               sd, bk, bk_next;
  logic [AMT_W-1:0]   filled, filled_next;
  logic               full, full_next;
  logic [CW-1:0]      buy_cnt, sell_cnt, buy_cnt_next, sell_cnt_next;
  logic [BW-1:0]      backlog, backlog_next;
  logic [KEY_W-1:0]   cur, cur_next, lval, lval_next;
  logic [AW-1:0]      idx, idx_next;
  logic               done_next;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [KEY_W-1:0]   wdata, rdata, rdata_buy, rdata_sell;
  logic               mod_start, mod_done;

  logic [CW-1:0]      cur_cnt, cnt_dec;
  logic [AW+1:0]      l_idx, r_idx, cnt_ext;
  logic               l_ok, r_ok, is_max, no_cross, l_win, r_win, up_win;
  logic [PRICE_W-1:0] top_p;
  logic [AMT_W-1:0]   top_a, take;
  logic [KEY_W-1:0]   best1;

  lobm_ram #(.WIDTH(KEY_W), .DEPTH(BOOK_DEPTH)) u_buy (
    .clk, .we(we && bk == BOOK_BUY), .waddr, .wdata, .raddr, .rdata(rdata_buy)
  );
  lobm_ram #(.WIDTH(KEY_W), .DEPTH(BOOK_DEPTH)) u_sell (
    .clk, .we(we && bk == BOOK_SELL), .waddr, .wdata, .raddr, .rdata(rdata_sell)
  );
  lobm_modred #(.IN_W(BW)) u_mod (
    .clk, .rst, .start(mod_start), .value(backlog), .done(mod_done), .result(backlog_mod)
  );

  assign rdata    = (bk == BOOK_SELL) ? rdata_sell : rdata_buy;
  assign cur_cnt  = (bk == BOOK_SELL) ? sell_cnt : buy_cnt;
  assign cnt_dec  = cur_cnt - 1'b1;
  assign is_max   = (bk == BOOK_BUY);
  assign top_p    = rdata[KEY_W-1:AMT_W];
  assign top_a    = rdata[AMT_W-1:0];
  assign no_cross = sd ? (top_p < px) : (top_p > px);
  assign take     = (amt < top_a) ? amt : top_a;
  assign l_idx    = {1'b0, idx, 1'b1};
  assign r_idx    = l_idx + 1'b1;
  assign cnt_ext  = (AW+2)'(cur_cnt);
  assign l_ok     = l_idx < cnt_ext;
  assign r_ok     = r_idx < cnt_ext;
  assign l_win    = ahead(lval, cur, is_max);
  assign best1    = l_win ? lval : cur;
  assign r_win    = r_ok && ahead(rdata, best1, is_max);
  assign up_win   = ahead(cur, rdata, is_max);
  assign busy     = (state != ST_IDLE);
  assign filled_amount = filled;
  assign book_full     = full;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (start) state_next = (amount == '0) ? ST_MOD_GO : ST_MATCH_RD;
      ST_MATCH_RD:  state_next = (amt == '0 || cur_cnt == '0) ? ST_INS : ST_MATCH_CHK;
      ST_MATCH_CHK: begin
        if (no_cross) state_next = ST_INS;
        else if (take == top_a) state_next = ST_POP_RD;
        else state_next = ST_SD_L;
      end
      ST_POP_RD:    state_next = ST_SD_L;
      ST_SD_L:      state_next = l_ok ? ST_SD_R : ST_MATCH_RD;
      ST_SD_R:      state_next = ST_SD_DEC;
      ST_SD_DEC:    state_next = (r_win || l_win) ? ST_SD_L : ST_MATCH_RD;
      ST_INS: begin
        if (amt == '0 || cur_cnt == CW'(BOOK_DEPTH)) state_next = ST_MOD_GO;
        else state_next = ST_SU_P;
      end
      ST_SU_P:      state_next = (idx == '0) ? ST_MOD_GO : ST_SU_DEC;
      ST_SU_DEC:    state_next = up_win ? ST_SU_P : ST_MOD_GO;
      ST_MOD_GO:    state_next = ST_MOD_WAIT;
      ST_MOD_WAIT:  if (mod_done) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    amt_next      = amt;
    bk_next       = bk;
    filled_next   = filled;
    full_next     = full;
    buy_cnt_next  = buy_cnt;
    sell_cnt_next = sell_cnt;
    backlog_next  = backlog;
    cur_next      = cur;
    lval_next     = lval;
    idx_next      = idx;
    done_next     = 1'b0;
    we            = 1'b0;
    waddr         = idx;
    wdata         = cur;
    raddr         = '0;
    mod_start     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          amt_next    = amount;
          bk_next     = ~side;
          filled_next = '0;
          full_next   = 1'b0;
        end
      end
      ST_MATCH_RD: raddr = '0;
      ST_MATCH_CHK: begin
        if (!no_cross) begin
          amt_next     = amt - take;
          filled_next  = filled + take;
          backlog_next = backlog - BW'(take);
          idx_next     = '0;
          cur_next     = {top_p, top_a - take};
          if (take == top_a) begin
            raddr = cnt_dec[AW-1:0];
            if (bk == BOOK_SELL) sell_cnt_next = cnt_dec;
            else buy_cnt_next = cnt_dec;
          end
        end
      end
      ST_POP_RD: cur_next = rdata;
      ST_SD_L: begin
        raddr = l_idx[AW-1:0];
        if (!l_ok) we = 1'b1;
      end
      ST_SD_R: begin
        lval_next = rdata;
        raddr     = r_idx[AW-1:0];
      end
      ST_SD_DEC: begin
        we = 1'b1;
        if (r_win) begin
          wdata    = rdata;
          idx_next = r_idx[AW-1:0];
        end else if (l_win) begin
          wdata    = lval;
          idx_next = l_idx[AW-1:0];
        end
      end
      ST_INS: begin
        if (amt != '0) begin
          if (cur_cnt == CW'(BOOK_DEPTH)) begin
            full_next = 1'b1;
          end else begin
            cur_next     = {px, amt};
            idx_next     = cur_cnt[AW-1:0];
            backlog_next = backlog + BW'(amt);
            if (bk == BOOK_SELL) sell_cnt_next = cur_cnt + 1'b1;
            else buy_cnt_next = cur_cnt + 1'b1;
          end
        end
      end
      ST_SU_P: begin
        raddr = (idx - 1'b1) >> 1;
        if (idx == '0) we = 1'b1;
      end
      ST_SU_DEC: begin
        we = 1'b1;
        if (up_win) begin
          wdata    = rdata;
          idx_next = (idx - 1'b1) >> 1;
        end
      end
      ST_MOD_GO:   mod_start = 1'b1;
      ST_MOD_WAIT: done_next = mod_done;
      default: ;
    endcase
    if (state == ST_MATCH_CHK && no_cross) bk_next = sd;
    if (state == ST_MATCH_RD && (amt == '0 || cur_cnt == '0)) bk_next = sd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      buy_cnt  <= '0;
      sell_cnt <= '0;
      backlog  <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      buy_cnt  <= buy_cnt_next;
      sell_cnt <= sell_cnt_next;
      backlog  <= backlog_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      px <= price;
      sd <= side;
    end
    amt    <= amt_next;
    bk     <= bk_next;
    filled <= filled_next;
    full   <= full_next;
    cur    <= cur_next;
    lval   <= lval_next;
    idx    <= idx_next;
  end

  `LOBM_ASSERT_IMPL(a_done_idle, done, !busy)
  `LOBM_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `LOBM_ASSERT_IMPL(a_cnt_range, 1'b1, buy_cnt <= CW'(BOOK_DEPTH) && sell_cnt <= CW'(BOOK_DEPTH))
  `LOBM_ASSERT_IMPL(a_full_rest, done && book_full, amt != '0)
endmodule
